>>> rtl/gct_pkg.sv
// Shared constants and codes for the generational capability table.
package gct_pkg;

    localparam int SLOTS_DEF       = 4096;
    localparam int OBJECT_BITS_DEF = 48;
    localparam int RIGHTS_BITS_DEF = 64;

    localparam int MODE_W   = 2;
    localparam int OBJ_W    = 48;
    localparam int RIGHTS_W = 64;
    localparam int TOKEN_W  = 32;
    localparam int GEN_W    = 32;
    localparam int STATUS_W = 3;
    localparam int NIDX_W   = 12;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESOLVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STALE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd5;

endpackage

>>> rtl/gct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module gct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/generational_capability_table_unit.sv
// Top level of the generational capability table.
//
// Request words carry an operation (allocate, resolve or free) with an object
// reference, a rights mask and a token. Each request word yields exactly one
// response word with a status, the resolved object and, for an allocation,
// the new token. Both channels use a valid and ready handshake.
// A request word is accepted only while no other request is in flight. The
// response word is registered when the operation completes, and the request
// side opens again in the same cycle as the response becomes valid, so the
// block takes no new word before the last one completes. Each word is the
// registered read of the slot memory followed by its write-back on the same port pair.
// A finished response waits in the output register while the next request is
// taken; while the receiver stalls with a response still held, the block
// completes no further word and holds its request side after one more accept.
// Reset empties all slots and links the free stack over slots one upward in
// order. Slots never handed out are tracked by a high-water mark, so no
// clearing pass is needed and the block is ready right after reset.
module generational_capability_table_unit #(
    parameter int SLOTS       = gct_pkg::SLOTS_DEF,
    parameter int OBJECT_BITS = gct_pkg::OBJECT_BITS_DEF,
    parameter int RIGHTS_BITS = gct_pkg::RIGHTS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [gct_pkg::MODE_W-1:0]    mode,
    input  logic [gct_pkg::OBJ_W-1:0]     object_ref,
    input  logic [gct_pkg::RIGHTS_W-1:0]  rights_mask,
    input  logic [gct_pkg::TOKEN_W-1:0]   token_index,
    input  logic [gct_pkg::TOKEN_W-1:0]   token_generation,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [gct_pkg::STATUS_W-1:0]  status,
    output logic [gct_pkg::OBJ_W-1:0]     found_object,
    output logic [gct_pkg::NIDX_W-1:0]    new_index,
    output logic [gct_pkg::GEN_W-1:0]     new_generation
);

    import gct_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int HWM_W  = ADDR_W + 1;

    localparam int LINK_LO = 0;
    localparam int OBJ_LO  = LINK_LO + ADDR_W;
    localparam int RGT_LO  = OBJ_LO + OBJECT_BITS;
    localparam int GEN_LO  = RGT_LO + RIGHTS_BITS;
    localparam int USE_BIT = GEN_LO + GEN_W;
    localparam int WORD_W  = USE_BIT + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [ADDR_W-1:0]      free_top_reg;
    logic [ADDR_W-1:0]      free_top_next;
    logic [HWM_W-1:0]       hwm_reg;
    logic [HWM_W-1:0]       hwm_next;
    logic [GEN_W-1:0]       gen_cnt_reg;
    logic [GEN_W-1:0]       gen_cnt_next;

    logic [MODE_W-1:0]      mode_reg;
    logic [OBJECT_BITS-1:0] obj_reg;
    logic [RIGHTS_BITS-1:0] rights_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic [GEN_W-1:0]       tok_gen_reg;
    logic                   bad_idx_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [OBJ_W-1:0]       found_reg;
    logic [NIDX_W-1:0]      nidx_reg;
    logic [GEN_W-1:0]       ngen_reg;

    logic                   accept;
    logic                   done;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic                   ram_we;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;

    logic [ADDR_W-1:0]      rd_link;
    logic [OBJECT_BITS-1:0] rd_obj;
    logic [RIGHTS_BITS-1:0] rd_rights;
    logic [GEN_W-1:0]       rd_gen;
    logic                   rd_use;

    logic                   live;
    logic                   token_ok;
    logic                   alloc_ok;
    logic                   free_ok;
    logic                   pristine;
    logic [HWM_W-1:0]       top_plus;
    logic [ADDR_W-1:0]      pop_link;
    logic [GEN_W-1:0]       stamp;
    logic [STATUS_W-1:0]    res_status;
    logic [OBJ_W-1:0]       res_found;
    logic [NIDX_W-1:0]      res_nidx;
    logic [GEN_W-1:0]       res_ngen;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign done      = (state_reg == S_EXEC) && (!out_valid_reg || rsp_ready);

    assign ram_re    = accept;
    assign ram_raddr = (mode == MODE_ALLOC) ? free_top_reg : token_index[ADDR_W-1:0];

    gct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_link   = ram_rdata[LINK_LO +: ADDR_W];
    assign rd_obj    = ram_rdata[OBJ_LO +: OBJECT_BITS];
    assign rd_rights = ram_rdata[RGT_LO +: RIGHTS_BITS];
    assign rd_gen    = ram_rdata[GEN_LO +: GEN_W];
    assign rd_use    = ram_rdata[USE_BIT];

    always_comb
    begin
        pristine      = ({1'b0, idx_reg} >= hwm_reg);
        live          = !pristine && rd_use;
        token_ok      = !bad_idx_reg && live && (rd_gen == tok_gen_reg);
        top_plus      = {1'b0, idx_reg} + HWM_W'(1);
        pop_link      = (top_plus < HWM_W'(SLOTS)) ? top_plus[ADDR_W-1:0] : '0;
        stamp         = (gen_cnt_reg == '0) ? GEN_W'(1) : gen_cnt_reg;
        alloc_ok      = 1'b0;
        free_ok       = 1'b0;
        res_status    = ST_OK;
        res_found     = '0;
        res_nidx      = '0;
        res_ngen      = '0;
        ram_wdata     = ram_rdata;
        free_top_next = free_top_reg;
        hwm_next      = hwm_reg;
        gen_cnt_next  = gen_cnt_reg;

        case (mode_reg)
            MODE_ALLOC:
            begin
                if (obj_reg == '0)
                begin
                    res_status = ST_NULL;
                end
                else if (free_top_reg == '0)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    alloc_ok     = 1'b1;
                    res_nidx     = NIDX_W'(idx_reg);
                    res_ngen     = stamp;
                    gen_cnt_next = stamp + GEN_W'(1);
                    if (pristine)
                    begin
                        free_top_next = pop_link;
                        hwm_next      = top_plus;
                    end
                    else
                    begin
                        free_top_next = rd_link;
                    end
                    ram_wdata = {1'b1, stamp, rights_reg, obj_reg, free_top_next};
                end
            end
            MODE_RESOLVE:
            begin
                if (bad_idx_reg)
                begin
                    res_status = ST_BAD_INDEX;
                end
                else if (!token_ok)
                begin
                    res_status = ST_STALE;
                end
                else if ((rd_rights & rights_reg) != rights_reg)
                begin
                    res_status = ST_DENIED;
                end
                else
                begin
                    res_found = OBJ_W'(rd_obj);
                end
            end
            MODE_FREE:
            begin
                if (bad_idx_reg)
                begin
                    res_status = ST_BAD_INDEX;
                end
                else if (!token_ok)
                begin
                    res_status = ST_STALE;
                end
                else
                begin
                    free_ok       = 1'b1;
                    free_top_next = idx_reg;
                    ram_wdata     = {1'b0, rd_gen, {RIGHTS_BITS{1'b0}},
                                     {OBJECT_BITS{1'b0}}, free_top_reg};
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign ram_we = done && (alloc_ok || free_ok);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_top_reg  <= ADDR_W'(1);
            hwm_reg       <= HWM_W'(1);
            gen_cnt_reg   <= GEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                free_top_reg  <= free_top_next;
                hwm_reg       <= hwm_next;
                gen_cnt_reg   <= gen_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            obj_reg     <= OBJECT_BITS'(object_ref);
            rights_reg  <= RIGHTS_BITS'(rights_mask);
            idx_reg     <= (mode == MODE_ALLOC) ? free_top_reg : token_index[ADDR_W-1:0];
            tok_gen_reg <= token_generation;
            bad_idx_reg <= (token_index == '0) || (token_index >= TOKEN_W'(SLOTS));
        end
        if (done)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            nidx_reg   <= res_nidx;
            ngen_reg   <= res_ngen;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_object   = found_reg;
    assign new_index      = nidx_reg;
    assign new_generation = ngen_reg;

    // The high-water mark never drops below one and never passes the table size.
    a_hwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hwm_reg != '0) && (hwm_reg <= HWM_W'(SLOTS)))
        else $error("high-water mark out of range");

    // The slot memory is written only when an operation completes.
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC) && done)
        else $error("slot memory written outside completion");

    // A successful allocation never hands out generation zero.
    a_alloc_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && alloc_ok) |=> rsp_valid && (status == ST_OK) && (new_generation != '0))
        else $error("allocation returned generation zero");

    // A successful free puts the freed slot on top of the free stack.
    a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
        (done && free_ok) |=> (free_top_reg == $past(idx_reg)))
        else $error("freed slot not on top of free stack");

    // An accepted word always moves the block out of idle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && !req_ready)
        else $error("accepted word did not start execution");

endmodule
